FILE: rtl/core/h2r_pkg.sv
// h2r_pkg: field widths and fixed constants of the HSL to RGB converter.
// No dependencies; compiled first.
package h2r_pkg;

    // Field widths of the pixel channels
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int CH_W  = 8;

    // Input ranges
    localparam int HUE_TURN = 360;
    localparam int PCT_FULL = 100;

    // Reciprocal for the hue remainder (x < 2^HX_W), divide by 360
    localparam int HX_W = 17;
    localparam int HK   = 26;
    localparam int HM_W = 18;
    localparam int HM   = (1 << HK) / HUE_TURN;

    // Reciprocal for the percent remainder (x < 2^PX_W), divide by 100
    localparam int PX_W = 14;
    localparam int PK   = 21;
    localparam int PM_W = 15;
    localparam int PM   = (1 << PK) / PCT_FULL;

endpackage

FILE: rtl/core/h2r_if.sv
// h2r_if: valid/ready channels for HSL input words and RGB output words.
// Depends on h2r_pkg for field widths.
interface h2r_hsl_if;
    logic                       valid;
    logic                       ready;
    logic [h2r_pkg::HUE_W-1:0]  hue_deg;
    logic [h2r_pkg::PCT_W-1:0]  sat_pct;
    logic [h2r_pkg::PCT_W-1:0]  light_pct;

    modport source (output valid, hue_deg, sat_pct, light_pct, input ready);
    modport sink   (input valid, hue_deg, sat_pct, light_pct, output ready);
endinterface

interface h2r_rgb_if;
    logic                      valid;
    logic                      ready;
    logic [h2r_pkg::CH_W-1:0]  red;
    logic [h2r_pkg::CH_W-1:0]  green;
    logic [h2r_pkg::CH_W-1:0]  blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: rtl/core/h2r_front.sv
// h2r_front: accepts HSL words, wraps/clamps them and scales them to fixed point.
// Three register stages; depends on h2r_pkg and h2r_hsl_if.
module h2r_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    h2r_hsl_if.sink                    pix,
    output logic                       word_valid,
    input  logic                       word_ready,
    output logic [3*FRAC_BITS+2:0]     word_data
);

    localparam int F    = FRAC_BITS;
    localparam int QW   = F + 1;
    localparam int HW   = h2r_pkg::HUE_W;
    localparam int PW   = h2r_pkg::PCT_W;
    localparam int HXW  = h2r_pkg::HX_W;
    localparam int PXW  = h2r_pkg::PX_W;
    localparam int HPW  = h2r_pkg::HX_W + h2r_pkg::HM_W;
    localparam int PPW  = h2r_pkg::PX_W + h2r_pkg::PM_W;
    localparam int HQW  = HPW - h2r_pkg::HK;
    localparam int PQW  = PPW - h2r_pkg::PK;
    localparam longint unsigned ONE = 64'd1 << F;
    localparam longint unsigned QH  = ONE / h2r_pkg::HUE_TURN;
    localparam longint unsigned RH  = ONE % h2r_pkg::HUE_TURN;
    localparam longint unsigned QP  = ONE / h2r_pkg::PCT_FULL;
    localparam longint unsigned RP  = ONE % h2r_pkg::PCT_FULL;

    logic            front_adv;

    // stage 1: wrapped and clamped fields, remainders to divide
    logic [HW-1:0]   hue_next, s1_hue_reg;
    logic [PW-1:0]   sat_next, s1_sat_reg;
    logic [PW-1:0]   light_next, s1_light_reg;
    logic [HXW-1:0]  xh_next, s1_xh_reg;
    logic [PXW-1:0]  xs_next, s1_xs_reg;
    logic [PXW-1:0]  xl_next, s1_xl_reg;
    logic            s1_valid_reg;

    // stage 2: quotient estimates
    logic [HPW-1:0]  hprod;
    logic [PPW-1:0]  sprod, lprod;
    logic [HW-1:0]   s2_hue_reg;
    logic [PW-1:0]   s2_sat_reg, s2_light_reg;
    logic [HXW-1:0]  s2_xh_reg;
    logic [PXW-1:0]  s2_xs_reg, s2_xl_reg;
    logic [HQW-1:0]  s2_qh_reg;
    logic [PQW-1:0]  s2_qs_reg, s2_ql_reg;
    logic            s2_valid_reg;

    // stage 3: corrected fixed-point values
    logic [HXW-1:0]  hrem;
    logic [QW-1:0]   h_full;
    logic [QW-1:0]   s_next, l_next;
    logic            grey_next;
    logic [3*F+2:0]  word_next, s3_word_reg;
    logic            s3_valid_reg;

    // percent to fixed point with remainder correction
    function automatic logic [QW-1:0] pct_to_fix(
        input logic [PW-1:0]  p,
        input logic [PXW-1:0] x,
        input logic [PQW-1:0] q
    );
        logic [PXW-1:0] rem;
        rem = x - PXW'(q) * PXW'(h2r_pkg::PCT_FULL);
        return QW'(p) * QW'(QP) + QW'(q) + QW'(rem >= PXW'(h2r_pkg::PCT_FULL));
    endfunction

    assign front_adv  = !s3_valid_reg || word_ready;
    assign pix.ready  = front_adv;
    assign word_valid = s3_valid_reg;
    assign word_data  = s3_word_reg;

    // stage 1 logic
    always_comb
    begin
        hue_next   = (pix.hue_deg >= HW'(h2r_pkg::HUE_TURN))
                   ? pix.hue_deg - HW'(h2r_pkg::HUE_TURN) : pix.hue_deg;
        sat_next   = (pix.sat_pct > PW'(h2r_pkg::PCT_FULL))
                   ? PW'(h2r_pkg::PCT_FULL) : pix.sat_pct;
        light_next = (pix.light_pct > PW'(h2r_pkg::PCT_FULL))
                   ? PW'(h2r_pkg::PCT_FULL) : pix.light_pct;
        xh_next    = HXW'(hue_next) * HXW'(RH) + HXW'(h2r_pkg::HUE_TURN / 2);
        xs_next    = PXW'(sat_next) * PXW'(RP) + PXW'(h2r_pkg::PCT_FULL / 2);
        xl_next    = PXW'(light_next) * PXW'(RP) + PXW'(h2r_pkg::PCT_FULL / 2);
    end

    // stage 2 logic: multiply by reciprocal, estimate may be one low
    assign hprod = HPW'(s1_xh_reg) * HPW'(h2r_pkg::HM);
    assign sprod = PPW'(s1_xs_reg) * PPW'(h2r_pkg::PM);
    assign lprod = PPW'(s1_xl_reg) * PPW'(h2r_pkg::PM);

    // stage 3 logic: correct quotient, add integer part
    always_comb
    begin
        hrem      = s2_xh_reg - HXW'(s2_qh_reg) * HXW'(h2r_pkg::HUE_TURN);
        h_full    = QW'(s2_hue_reg) * QW'(QH) + QW'(s2_qh_reg)
                  + QW'(hrem >= HXW'(h2r_pkg::HUE_TURN));
        s_next    = pct_to_fix(s2_sat_reg, s2_xs_reg, s2_qs_reg);
        l_next    = pct_to_fix(s2_light_reg, s2_xl_reg, s2_ql_reg);
        grey_next = (s2_sat_reg == '0);
        word_next = {grey_next, h_full[F-1:0], s_next, l_next};
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            s1_valid_reg <= pix.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            s1_hue_reg   <= hue_next;
            s1_sat_reg   <= sat_next;
            s1_light_reg <= light_next;
            s1_xh_reg    <= xh_next;
            s1_xs_reg    <= xs_next;
            s1_xl_reg    <= xl_next;
            s2_hue_reg   <= s1_hue_reg;
            s2_sat_reg   <= s1_sat_reg;
            s2_light_reg <= s1_light_reg;
            s2_xh_reg    <= s1_xh_reg;
            s2_xs_reg    <= s1_xs_reg;
            s2_xl_reg    <= s1_xl_reg;
            s2_qh_reg    <= hprod[HPW-1:h2r_pkg::HK];
            s2_qs_reg    <= sprod[PPW-1:h2r_pkg::PK];
            s2_ql_reg    <= lprod[PPW-1:h2r_pkg::PK];
            s3_word_reg  <= word_next;
        end
    end

endmodule

FILE: rtl/core/h2r_queue.sv
// h2r_queue: small register FIFO between the front and back pipelines.
// Standalone; no package use.
module h2r_queue #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

FILE: rtl/core/h2r_back.sv
// h2r_back: hue-to-channel evaluation for three lanes and the RGB output register.
// Six register stages; depends on h2r_pkg and h2r_rgb_if.
module h2r_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    word_valid,
    output logic                    word_ready,
    input  logic [3*FRAC_BITS+2:0]  word_data,
    h2r_rgb_if.source               pix
);

    localparam int F   = FRAC_BITS;
    localparam int QW  = F + 1;
    localparam int LW  = F + 2;
    localparam int CW  = h2r_pkg::CH_W;
    localparam int NCH = 3;
    localparam longint unsigned ONE        = 64'd1 << F;
    localparam longint unsigned THIRD      = ONE / 3;
    localparam longint unsigned TWO_THIRDS = (2 * ONE) / 3;

    // lane order
    localparam int LANE_R = 0;
    localparam int LANE_G = 1;
    localparam int LANE_B = 2;

    // piece of the hue-to-channel curve
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } seg_t;

    logic            back_adv;
    logic            out_valid_reg;

    // b1: unpack, l*s product
    logic            in_grey;
    logic [F-1:0]    in_h;
    logic [QW-1:0]   in_s, in_l;
    logic [2*QW-1:0] ls_prod;
    logic            b1_valid_reg, b1_grey_reg;
    logic [F-1:0]    b1_h_reg;
    logic [QW-1:0]   b1_s_reg, b1_l_reg, b1_ls_reg;

    // b2: hi/lo levels, lane positions
    logic            light_low;
    logic [LW-1:0]   hi_next, lo_next, lo_sum;
    logic [QW-1:0]   tr_sum;
    logic [QW-1:0]   t_next [NCH];
    logic            b2_valid_reg, b2_grey_reg;
    logic [QW-1:0]   b2_l_reg;
    logic [LW-1:0]   b2_hi_reg, b2_lo_reg;
    logic [QW-1:0]   b2_t_reg [NCH];

    // b3: span, segment and multiplier operand per lane
    logic [LW-1:0]   span_next;
    logic [F+3:0]    t6  [NCH];
    logic [F+2:0]    t3  [NCH];
    logic [QW-1:0]   d_val [NCH];
    logic [F+3:0]    d6  [NCH];
    seg_t            seg_next [NCH];
    logic [QW-1:0]   m_next [NCH];
    logic            b3_valid_reg, b3_grey_reg;
    logic [QW-1:0]   b3_l_reg;
    logic [LW-1:0]   b3_hi_reg, b3_lo_reg, b3_span_reg;
    seg_t            b3_seg_reg [NCH];
    logic [QW-1:0]   b3_m_reg [NCH];

    // b4: ramp products
    logic [LW+QW-1:0] ramp [NCH];
    logic            b4_valid_reg, b4_grey_reg;
    logic [QW-1:0]   b4_l_reg;
    logic [LW-1:0]   b4_hi_reg, b4_lo_reg;
    seg_t            b4_seg_reg [NCH];
    logic [LW-1:0]   b4_prod_reg [NCH];

    // b5: channel level held within 0..ONE
    logic [LW:0]     lvl [NCH];
    logic [QW-1:0]   v_next [NCH];
    logic            b5_valid_reg;
    logic [QW-1:0]   b5_v_reg [NCH];

    // output: scale to 0..255
    logic [F+8:0]    scaled [NCH];
    logic [CW-1:0]   byte_next [NCH];
    logic [CW-1:0]   red_reg, green_reg, blue_reg;

    assign back_adv   = !out_valid_reg || pix.ready;
    assign word_ready = back_adv;
    assign pix.valid  = out_valid_reg;
    assign pix.red    = red_reg;
    assign pix.green  = green_reg;
    assign pix.blue   = blue_reg;

    // b1 logic
    assign {in_grey, in_h, in_s, in_l} = word_data;
    assign ls_prod = (2*QW)'(in_l) * (2*QW)'(in_s);

    // b2 logic: hi = l + s*(l or 1-l), lo = 2l - hi floored at zero
    always_comb
    begin
        light_low = ({b1_l_reg, 1'b0} < (QW+1)'(ONE));
        lo_sum    = LW'(b1_l_reg) + LW'(b1_ls_reg);
        if (light_low)
        begin
            hi_next = lo_sum;
            lo_next = LW'(b1_l_reg) - LW'(b1_ls_reg);
        end
        else
        begin
            hi_next = LW'(b1_l_reg) + LW'(b1_s_reg) - LW'(b1_ls_reg);
            lo_next = (lo_sum >= LW'(b1_s_reg)) ? lo_sum - LW'(b1_s_reg) : '0;
        end
        tr_sum         = QW'(b1_h_reg) + QW'(THIRD);
        t_next[LANE_R] = (tr_sum > QW'(ONE)) ? tr_sum - QW'(ONE) : tr_sum;
        t_next[LANE_G] = QW'(b1_h_reg);
        t_next[LANE_B] = (b1_h_reg >= F'(THIRD)) ? QW'(b1_h_reg) - QW'(THIRD)
                       : QW'(b1_h_reg) + QW'(ONE) - QW'(THIRD);
    end

    // b3 logic: pick curve segment per lane
    always_comb
    begin
        span_next = (b2_hi_reg > b2_lo_reg) ? b2_hi_reg - b2_lo_reg : '0;
        for (int c = 0; c < NCH; c++)
        begin
            t6[c]    = (F+4)'(b2_t_reg[c]) * (F+4)'(6);
            t3[c]    = (F+3)'(b2_t_reg[c]) * (F+3)'(3);
            d_val[c] = (b2_t_reg[c] <= QW'(TWO_THIRDS))
                     ? QW'(TWO_THIRDS) - b2_t_reg[c] : '0;
            d6[c]    = (F+4)'(d_val[c]) * (F+4)'(6);
            priority if (t6[c] < (F+4)'(ONE))
            begin
                seg_next[c] = SEG_RISE;
                m_next[c]   = t6[c][QW-1:0];
            end
            else if ({b2_t_reg[c], 1'b0} < (QW+1)'(ONE))
            begin
                seg_next[c] = SEG_HIGH;
                m_next[c]   = '0;
            end
            else if (t3[c] < (F+3)'(2 * ONE))
            begin
                seg_next[c] = SEG_FALL;
                m_next[c]   = d6[c][QW-1:0];
            end
            else
            begin
                seg_next[c] = SEG_LOW;
                m_next[c]   = '0;
            end
        end
    end

    // b4 logic: span times ramp position
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
            ramp[c] = (LW+QW)'(b3_span_reg) * (LW+QW)'(b3_m_reg[c]);
    end

    // b5 logic: level per segment, grey bypass, clamp
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            unique case (b4_seg_reg[c])
                SEG_RISE, SEG_FALL: lvl[c] = (LW+1)'(b4_lo_reg) + (LW+1)'(b4_prod_reg[c]);
                SEG_HIGH:           lvl[c] = (LW+1)'(b4_hi_reg);
                SEG_LOW:            lvl[c] = (LW+1)'(b4_lo_reg);
                default:            lvl[c] = (LW+1)'(b4_lo_reg);
            endcase
            if (b4_grey_reg)
                lvl[c] = (LW+1)'(b4_l_reg);
            v_next[c] = (lvl[c] > (LW+1)'(ONE)) ? QW'(ONE) : lvl[c][QW-1:0];
        end
    end

    // output logic: (v * 255) >> F
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            scaled[c]    = (F+9)'(b5_v_reg[c]) * (F+9)'(255);
            byte_next[c] = scaled[c][F +: CW];
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            b1_valid_reg  <= word_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            out_valid_reg <= b5_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            b1_grey_reg <= in_grey;
            b1_h_reg    <= in_h;
            b1_s_reg    <= in_s;
            b1_l_reg    <= in_l;
            b1_ls_reg   <= ls_prod[F +: QW];

            b2_grey_reg <= b1_grey_reg;
            b2_l_reg    <= b1_l_reg;
            b2_hi_reg   <= hi_next;
            b2_lo_reg   <= lo_next;

            b3_grey_reg <= b2_grey_reg;
            b3_l_reg    <= b2_l_reg;
            b3_hi_reg   <= b2_hi_reg;
            b3_lo_reg   <= b2_lo_reg;
            b3_span_reg <= span_next;

            b4_grey_reg <= b3_grey_reg;
            b4_l_reg    <= b3_l_reg;
            b4_hi_reg   <= b3_hi_reg;
            b4_lo_reg   <= b3_lo_reg;

            for (int c = 0; c < NCH; c++)
            begin
                b2_t_reg[c]    <= t_next[c];
                b3_seg_reg[c]  <= seg_next[c];
                b3_m_reg[c]    <= m_next[c];
                b4_seg_reg[c]  <= b3_seg_reg[c];
                b4_prod_reg[c] <= ramp[c][F +: LW];
                b5_v_reg[c]    <= v_next[c];
            end

            red_reg   <= byte_next[LANE_R];
            green_reg <= byte_next[LANE_G];
            blue_reg  <= byte_next[LANE_B];
        end
    end

endmodule

FILE: rtl/core/hsl_to_rgb_convert.sv
// hsl_to_rgb_convert: top level of the HSL to RGB pixel converter.
// Instantiates h2r_front, h2r_queue and h2r_back; uses h2r_pkg and h2r_if.
//
// Usage:
//   pixel_hsl (sink) takes one word per cycle while its ready is high:
//   hue_deg (degrees), sat_pct and light_pct (percent). Hue of 360 or more
//   wraps once, percentages above 100 clamp to 100. pixel_rgb (source) gives
//   one word per input word: 8-bit red, green, blue, in input order.
//   Throughput is one word per clock while pixel_rgb is not stalled. A result
//   passes through three front stages (range fold, reciprocal multiply,
//   remainder fix), one queue slot and six back stages (l*s product, hi/lo,
//   segment pick, ramp multiply, clamp, output register).
//   When pixel_rgb stalls, the back pipeline freezes while the front keeps
//   taking words until the queue (QUEUE_DEPTH words) is full and the last front
//   stage holds a word; only then does pixel_hsl.ready drop.
//   Reset (rst_n low, asynchronous) empties all stages and the queue; no
//   clearing pass is needed, and words are accepted at the first edge after.
module hsl_to_rgb_convert #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    h2r_hsl_if.sink    pixel_hsl,
    h2r_rgb_if.source  pixel_rgb
);

    localparam int WORD_W = 3 * FRAC_BITS + 3;

    logic              fq_valid, fq_ready;
    logic [WORD_W-1:0] fq_data;
    logic              qb_valid, qb_ready;
    logic [WORD_W-1:0] qb_data;

    // front: classify and scale
    h2r_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pixel_hsl),
        .word_valid (fq_valid),
        .word_ready (fq_ready),
        .word_data  (fq_data)
    );

    // decoupling queue
    h2r_queue #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // back: channel evaluation
    h2r_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (qb_valid),
        .word_ready (qb_ready),
        .word_data  (qb_data),
        .pix        (pixel_rgb)
    );

endmodule

FILE: rtl/core/h2r_checker.sv
// h2r_checker: port-level checks of hsl_to_rgb_convert, attached by bind.
// Depends on h2r_pkg; binds to hsl_to_rgb_convert.
module h2r_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [h2r_pkg::CH_W-1:0]  red,
    input logic [h2r_pkg::CH_W-1:0]  green,
    input logic [h2r_pkg::CH_W-1:0]  blue
);

    // a stalled output word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // a stalled output word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("output word changed while stalled");

    // input back-pressure only follows output back-pressure
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without output stall");

    // no result before the pipeline depth has passed since reset
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n, 9) |-> !out_valid)
        else $error("result appeared too early after reset");

endmodule

bind hsl_to_rgb_convert h2r_checker u_h2r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixel_hsl.ready),
    .out_valid (pixel_rgb.valid),
    .out_ready (pixel_rgb.ready),
    .red       (pixel_rgb.red),
    .green     (pixel_rgb.green),
    .blue      (pixel_rgb.blue)
);
